### hdl/tjr_pkg.sv
`default_nettype none

package tjr_pkg;

   localparam int PosW      = 64;
   localparam int VelW      = 32;
   localparam int WorkW     = 34;   // working velocity, holds w + step before the clamp
   localparam int RateW     = 31;
   localparam int OffW      = 40;
   localparam int TickW     = 32;
   localparam int MagW      = 32;
   localparam int ProdW     = MagW + TickW;
   localparam int FracShift = 16;   // Q16.16 x Q0.32 -> Q32.32
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 40;

   localparam logic [RateW-1:0] MaxVelocityRst  = RateW'(655360);
   localparam logic [RateW-1:0] EndVelocityRst  = RateW'(0);
   localparam logic [RateW-1:0] AccelRateRst    = RateW'(131072);
   localparam logic [RateW-1:0] VelocityStepRst = RateW'(131);
   localparam logic [OffW-1:0]  RampOffsetRst   = OffW'(4295);
   localparam logic [TickW-1:0] TickPeriodRst   = TickW'(4294967);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MAX_VELOCITY  = 3'd0,
      CSR_END_VELOCITY  = 3'd1,
      CSR_ACCEL_RATE    = 3'd2,
      CSR_VELOCITY_STEP = 3'd3,
      CSR_RAMP_OFFSET   = 3'd4,
      CSR_TICK_PERIOD   = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SELECT,
      ST_ACC_TEST,
      ST_ACC_MUL,
      ST_ACC_TERM,
      ST_ACC_STEP,
      ST_CLAMP,
      ST_CRU_MUL,
      ST_CRU_TERM,
      ST_CRU_STEP,
      ST_DEC_TEST,
      ST_DEC_MUL,
      ST_DEC_TERM,
      ST_DEC_STEP,
      ST_DEC_END,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_LOAD_LOCK,
      OP_MUL,
      OP_TERM,
      OP_ACC_STEP,
      OP_DEC_STEP,
      OP_CLAMP,
      OP_CRUISE,
      OP_END,
      OP_WRITE,
      OP_OUT
   } dp_op_type;

   typedef enum logic [1:0] {
      OFS_NONE,
      OFS_ADD,
      OFS_SUB
   } ofs_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        dir;    // 0 forward, 1 backward
      ofs_sel_type ofs;
   } dp_cmd_type;

   typedef struct packed {
      logic fwd_req;
      logic bck_req;
      logic fwd_lock;
      logic bck_lock;
      logic w_lt_max;
      logic w_ge_max;
      logic w_gt_end;
      logic w_le_end;
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/tjr_ctrl.sv
`default_nettype none

module tjr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tjr_pkg::dp_status_type status,
   output tjr_pkg::dp_cmd_type    cmd
);
   import tjr_pkg::*;

   state_type state_ff, state_in;
   logic      dir_ff, dir_in;

   logic sel_req, own_lock, other_lock, acc_go, dec_go;

   assign sel_req    = dir_ff ? status.bck_req  : status.fwd_req;
   assign own_lock   = dir_ff ? status.bck_lock : status.fwd_lock;
   assign other_lock = dir_ff ? status.fwd_lock : status.bck_lock;
   assign acc_go     = sel_req && !other_lock;
   assign dec_go     = !sel_req && own_lock;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SELECT;
               dir_in   = 1'b0;
            end
         end
         ST_SELECT: begin
            if (acc_go) begin
               state_in = ST_ACC_TEST;
            end else if (dec_go) begin
               state_in = ST_DEC_TEST;
            end else if (!dir_ff) begin
               dir_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACC_TEST: state_in = status.w_lt_max ? ST_ACC_MUL : ST_CLAMP;
         ST_ACC_MUL:  state_in = ST_ACC_TERM;
         ST_ACC_TERM: state_in = ST_ACC_STEP;
         ST_ACC_STEP: state_in = ST_CLAMP;
         ST_CLAMP:    state_in = status.w_ge_max ? ST_CRU_MUL : ST_WRITE;
         ST_CRU_MUL:  state_in = ST_CRU_TERM;
         ST_CRU_TERM: state_in = ST_CRU_STEP;
         ST_CRU_STEP: state_in = ST_WRITE;
         ST_DEC_TEST: state_in = status.w_gt_end ? ST_DEC_MUL : ST_DEC_END;
         ST_DEC_MUL:  state_in = ST_DEC_TERM;
         ST_DEC_TERM: state_in = ST_DEC_STEP;
         ST_DEC_STEP: state_in = ST_DEC_END;
         ST_DEC_END:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (!dir_ff) begin
               dir_in   = 1'b1;
               state_in = ST_SELECT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.dir   = dir_ff;
      cmd.ofs   = OFS_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_CAPTURE;
            end
         end
         ST_SELECT: begin
            if (acc_go) begin
               cmd.op = OP_LOAD_LOCK;
            end else if (dec_go) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_ACC_TEST, ST_DEC_TEST: cmd.op = OP_NONE;
         ST_ACC_MUL, ST_CRU_MUL, ST_DEC_MUL: cmd.op = OP_MUL;
         ST_ACC_TERM: begin
            cmd.op  = OP_TERM;
            cmd.ofs = OFS_ADD;
         end
         ST_CRU_TERM: begin
            cmd.op  = OP_TERM;
            cmd.ofs = OFS_NONE;
         end
         ST_DEC_TERM: begin
            cmd.op  = OP_TERM;
            cmd.ofs = OFS_SUB;
         end
         ST_ACC_STEP: cmd.op = OP_ACC_STEP;
         ST_CLAMP:    cmd.op = OP_CLAMP;
         ST_CRU_STEP: cmd.op = OP_CRUISE;
         ST_DEC_STEP: cmd.op = OP_DEC_STEP;
         ST_DEC_END:  cmd.op = status.w_le_end ? OP_END : OP_NONE;
         ST_WRITE:    cmd.op = OP_WRITE;
         ST_DONE:     cmd.op = status.out_busy ? OP_NONE : OP_OUT;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

### hdl/tjr_dp.sv
`default_nettype none

module tjr_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tjr_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [tjr_pkg::CsrDataW-1:0]          csr_write_data,
   input  logic                                  req_forward_request,
   input  logic                                  req_backward_request,
   input  tjr_pkg::dp_cmd_type                   cmd,
   output tjr_pkg::dp_status_type                status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tjr_pkg::PosW-1:0]       rsp_position,
   output logic signed [tjr_pkg::VelW-1:0]       rsp_velocity,
   output logic        [tjr_pkg::RateW-1:0]      rsp_accel_magnitude,
   output logic                                  rsp_forward_active,
   output logic                                  rsp_backward_active
);
   import tjr_pkg::*;

   // configuration
   logic [RateW-1:0] max_vel_ff, end_vel_ff, accel_rate_ff, vel_step_ff;
   logic [OffW-1:0]  ramp_off_ff;
   logic [TickW-1:0] tick_ff;

   // axis state
   logic [PosW-1:0]         pos_ff, pos_in;
   logic signed [VelW-1:0]  vel_ff, vel_in;
   logic [RateW-1:0]        accel_ff, accel_in;
   logic                    fwd_lock_ff, fwd_lock_in;
   logic                    bck_lock_ff, bck_lock_in;

   // working registers
   logic signed [WorkW-1:0] w_ff, w_in;
   logic [ProdW-1:0]        prod_ff, prod_in;
   logic [PosW-1:0]         term_ff, term_in;
   logic                    fwd_req_ff, fwd_req_in;
   logic                    bck_req_ff, bck_req_in;

   // result item
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PosW-1:0]         out_pos_ff;
   logic [VelW-1:0]         out_vel_ff;
   logic [RateW-1:0]        out_accel_ff;
   logic                    out_fwd_ff, out_bck_ff;

   logic signed [WorkW-1:0] vel_ext, max_ext, end_ext, step_ext, w_abs;
   logic [MagW-1:0]         w_mag;
   logic [PosW-1:0]         pm, pm_x, off_ext, off_x;
   logic                    w_neg, ofs_sub;
   logic [VelW-1:0]         w_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_vel_ff    <= MaxVelocityRst;
         end_vel_ff    <= EndVelocityRst;
         accel_rate_ff <= AccelRateRst;
         vel_step_ff   <= VelocityStepRst;
         ramp_off_ff   <= RampOffsetRst;
         tick_ff       <= TickPeriodRst;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_VELOCITY:  max_vel_ff    <= csr_write_data[RateW-1:0];
            CSR_END_VELOCITY:  end_vel_ff    <= csr_write_data[RateW-1:0];
            CSR_ACCEL_RATE:    accel_rate_ff <= csr_write_data[RateW-1:0];
            CSR_VELOCITY_STEP: vel_step_ff   <= csr_write_data[RateW-1:0];
            CSR_RAMP_OFFSET:   ramp_off_ff   <= csr_write_data[OffW-1:0];
            CSR_TICK_PERIOD:   tick_ff       <= csr_write_data[TickW-1:0];
            default: ;
         endcase
      end
   end

   assign vel_ext  = {{(WorkW-VelW){vel_ff[VelW-1]}}, vel_ff};
   assign max_ext  = {{(WorkW-RateW){1'b0}}, max_vel_ff};
   assign end_ext  = {{(WorkW-RateW){1'b0}}, end_vel_ff};
   assign step_ext = {{(WorkW-RateW){1'b0}}, vel_step_ff};

   assign w_neg = w_ff[WorkW-1];
   assign w_abs = w_neg ? -w_ff : w_ff;
   assign w_mag = w_abs[MagW-1:0];     // |w| never exceeds 2^31 where it is multiplied
   assign w_low = w_ff[VelW-1:0];

   // v*dt toward zero: negate the truncated magnitude, fold offset in, one add
   assign pm      = {{FracShift{1'b0}}, prod_ff[ProdW-1:FracShift]};
   assign pm_x    = pm ^ {PosW{w_neg}};
   assign off_ext = {{(PosW-OffW){1'b0}}, ramp_off_ff};
   assign ofs_sub = (cmd.ofs == OFS_SUB);
   always_comb begin
      case (cmd.ofs)
         OFS_ADD: off_x = off_ext;
         OFS_SUB: off_x = ~off_ext;
         default: off_x = '0;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      accel_in     = accel_ff;
      fwd_lock_in  = fwd_lock_ff;
      bck_lock_in  = bck_lock_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      term_in      = term_ff;
      fwd_req_in   = fwd_req_ff;
      bck_req_in   = bck_req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         OP_NONE: ;
         OP_CAPTURE: begin
            fwd_req_in = req_forward_request;
            bck_req_in = req_backward_request;
         end
         OP_LOAD: w_in = cmd.dir ? -vel_ext : vel_ext;
         OP_LOAD_LOCK: begin
            w_in = cmd.dir ? -vel_ext : vel_ext;
            if (cmd.dir) begin
               bck_lock_in = 1'b1;
            end else begin
               fwd_lock_in = 1'b1;
            end
         end
         OP_MUL:  prod_in = w_mag * tick_ff;
         OP_TERM: term_in = pm_x + off_x + PosW'(w_neg) + PosW'(ofs_sub);
         OP_ACC_STEP: begin
            pos_in   = cmd.dir ? pos_ff - term_ff : pos_ff + term_ff;
            w_in     = w_ff + step_ext;
            accel_in = accel_rate_ff;
         end
         OP_DEC_STEP: begin
            pos_in   = cmd.dir ? pos_ff - term_ff : pos_ff + term_ff;
            w_in     = w_ff - step_ext;
            accel_in = accel_rate_ff;
         end
         OP_CLAMP: begin
            if (w_ff > max_ext) begin
               w_in = max_ext;
            end
         end
         OP_CRUISE: begin
            pos_in   = cmd.dir ? pos_ff - term_ff : pos_ff + term_ff;
            accel_in = '0;
         end
         OP_END: begin
            w_in     = end_ext;
            accel_in = '0;
            if (cmd.dir) begin
               bck_lock_in = 1'b0;
            end else begin
               fwd_lock_in = 1'b0;
            end
         end
         OP_WRITE: vel_in = cmd.dir ? -w_low : w_low;
         OP_OUT:   rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         vel_ff       <= '0;
         accel_ff     <= '0;
         fwd_lock_ff  <= 1'b0;
         bck_lock_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         accel_ff     <= accel_in;
         fwd_lock_ff  <= fwd_lock_in;
         bck_lock_ff  <= bck_lock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff       <= w_in;
      prod_ff    <= prod_in;
      term_ff    <= term_in;
      fwd_req_ff <= fwd_req_in;
      bck_req_ff <= bck_req_in;
      if (cmd.op == OP_OUT) begin
         out_pos_ff   <= pos_ff;
         out_vel_ff   <= vel_ff;
         out_accel_ff <= accel_ff;
         out_fwd_ff   <= fwd_lock_ff;
         out_bck_ff   <= bck_lock_ff;
      end
   end

   assign status.fwd_req  = fwd_req_ff;
   assign status.bck_req  = bck_req_ff;
   assign status.fwd_lock = fwd_lock_ff;
   assign status.bck_lock = bck_lock_ff;
   assign status.w_lt_max = (w_ff < max_ext);
   assign status.w_ge_max = (w_ff >= max_ext);
   assign status.w_gt_end = (w_ff > end_ext);
   assign status.w_le_end = (w_ff <= end_ext);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = out_pos_ff;
   assign rsp_velocity        = out_vel_ff;
   assign rsp_accel_magnitude = out_accel_ff;
   assign rsp_forward_active  = out_fwd_ff;
   assign rsp_backward_active = out_bck_ff;

endmodule

`default_nettype wire

### hdl/trapezoidal_jog_ramp.sv
`default_nettype none

// Trapezoidal jog ramp, one servo axis. Each req item is one servo tick
// carrying the forward and backward jog buttons; each tick returns one rsp
// item with position (Q32.32), velocity (Q16.16), acceleration magnitude
// and the two direction locks, all as they stand after the tick.
// The csr port writes the six profile registers; write them only while idle.
// Each tick walks the controller through each direction in turn (forward,
// then backward): load, test, multiply, offset, position update and
// writeback, on the one shared 32x32 multiplier.
// One tick is in work at a time; req_ready is high only while idle, so a
// new tick is taken only once the controller is through with the last one.
// The rsp item sits in its own register, so the next tick is accepted while
// it waits; a tick that finishes while the previous rsp is still stalled
// holds until rsp_ready frees the register.
// Reset (synchronous): position, velocity, acceleration and locks go to
// zero and the registers to their default profile.
module trapezoidal_jog_ramp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tjr_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [tjr_pkg::CsrDataW-1:0]          csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_forward_request,
   input  logic                                  req_backward_request,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tjr_pkg::PosW-1:0]       rsp_position,
   output logic signed [tjr_pkg::VelW-1:0]       rsp_velocity,
   output logic        [tjr_pkg::RateW-1:0]      rsp_accel_magnitude,
   output logic                                  rsp_forward_active,
   output logic                                  rsp_backward_active
);
   import tjr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tjr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tjr_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_forward_request  (req_forward_request),
      .req_backward_request (req_backward_request),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_position         (rsp_position),
      .rsp_velocity         (rsp_velocity),
      .rsp_accel_magnitude  (rsp_accel_magnitude),
      .rsp_forward_active   (rsp_forward_active),
      .rsp_backward_active  (rsp_backward_active)
   );

`ifndef NO_ASSERTIONS
   // the two directions lock each other out
   a_lock_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_forward_active && rsp_backward_active))
      else $error("both direction locks set");

   // with no move in progress there is no acceleration left over
   a_idle_no_accel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_forward_active && !rsp_backward_active)
         |-> (rsp_accel_magnitude == '0))
      else $error("acceleration reported with no active move");

   // one tick in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item accepted while a tick is in work");
`endif

endmodule

`default_nettype wire
